// ----- hw/rtl/deadline_timer_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Deadline timer queue: assertion macros
// Shared property wrappers for the checker; clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Sizes, codes and entry layout shared by the queue modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_FIRED   = 32;
    localparam int FCNT_W      = 6;
    localparam int DL_W        = 48;
    localparam int ID_W        = 32;
    localparam int TAG_W       = 32;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_PROCESS = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_CANCEL = 3'd1,
        KIND_FIRED  = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_NEXT   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_CB     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DECIDE
    } state_t;

    // One queue slot as held in the entry RAM
    typedef struct packed {
        logic signed [DL_W-1:0] deadline;
        logic [ID_W-1:0]        id;
        logic [TAG_W-1:0]       tag;
        logic                   cancelled;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Entry read back from the RAM, offered to the selector
    typedef struct packed {
        logic            vld;
        logic            hit;
        logic [IDX_W-1:0] idx;
        entry_t          entry;
    } sample_t;

    // Best candidate so far
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } best_t;

endpackage

// ----- hw/rtl/deadline_timer_queue.sv -----
// Add: decided in S_ADD; cancel and query scan every slot in S_SCAN, then answer from S_DECIDE.
// Process: a full scan finds each entry to pop, and a final scan ends the run with the done result.
// Throughput: one item at a time; each head search walks the entry RAM one slot per cycle
// through its single read port.
// Reset: slot valid bits and the id counter clear at once; entry RAM contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Deadline timer queue
// Bounded timer queue in an entry RAM, ordered by deadline then id.
// ----------------------------------------------------------------------------
module deadline_timer_queue
    import dtq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic signed [DL_W-1:0]   due_ms,
    input  logic                     has_callback,
    input  logic [TAG_W-1:0]         callback_tag,
    input  logic [ID_W-1:0]          target_id,
    input  logic signed [DL_W-1:0]   now_ms,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               kind,
    output logic [1:0]               status,
    output logic [ID_W-1:0]          result_id,
    output logic [TAG_W-1:0]         fired_tag,
    output logic signed [DL_W-1:0]   head_deadline,
    output logic                     queue_empty,
    output logic [FCNT_W-1:0]        fired_count,
    output logic                     last
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic signed [DL_W-1:0] arg_dl_reg, arg_dl_next;
    logic                   cb_reg, cb_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [ID_W-1:0]        tgt_reg, tgt_next;

    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]        idc_reg, idc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   rvld_reg, rvld_next;
    logic [IDX_W-1:0]       ridx_reg, ridx_next;
    logic [FCNT_W-1:0]      n_reg, n_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg, kind_next;
    status_t                status_reg, status_next;
    logic [ID_W-1:0]        tid_reg, tid_next;
    logic [TAG_W-1:0]       ftag_reg, ftag_next;
    logic signed [DL_W-1:0] hdl_reg, hdl_next;
    logic                   qe_reg, qe_next;
    logic [FCNT_W-1:0]      fcnt_reg, fcnt_next;
    logic                   last_reg, last_next;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata, ram_rdata;
    logic                   scan_clear;
    sample_t                sample;
    best_t                  best;

    logic                   out_free;
    logic                   full;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;

    // Entry storage
    dtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Head / match selection over the read stream
    assign sample.vld   = rvld_reg;
    assign sample.idx   = ridx_reg;
    assign sample.entry = ram_rdata;
    assign sample.hit   = valid_reg[ridx_reg] &&
                          ((op_reg != OP_CANCEL) || (ram_rdata.id == tgt_reg));

    dtq_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (scan_clear),
        .sample (sample),
        .best   (best)
    );

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (!valid_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign full     = !free_found;
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: next state, RAM accesses and result register
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        arg_dl_next    = arg_dl_reg;
        cb_next        = cb_reg;
        tag_next       = tag_reg;
        tgt_next       = tgt_reg;
        valid_next     = valid_reg;
        idc_next       = idc_reg;
        cnt_next       = cnt_reg;
        rvld_next      = 1'b0;
        ridx_next      = ridx_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        status_next    = status_reg;
        tid_next       = tid_reg;
        ftag_next      = ftag_reg;
        hdl_next       = hdl_reg;
        qe_next        = qe_reg;
        fcnt_next      = fcnt_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = best.idx;
        ram_wdata      = best.entry;
        scan_clear     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(operation);
                    arg_dl_next = (op_t'(operation) == OP_ADD) ? due_ms : now_ms;
                    cb_next     = has_callback;
                    tag_next    = callback_tag;
                    tgt_next    = target_id;
                    n_next      = '0;
                    cnt_next    = '0;
                    if (op_t'(operation) == OP_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        scan_clear = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ADD;
                    tid_next       = '0;
                    ftag_next      = '0;
                    hdl_next       = '0;
                    qe_next        = 1'b0;
                    fcnt_next      = '0;
                    last_next      = 1'b1;
                    if (!cb_reg)
                    begin
                        status_next = ST_NO_CB;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next              = ST_OK;
                        idc_next                 = idc_reg + 1'b1;
                        tid_next                 = idc_reg + 1'b1;
                        valid_next[free_idx]     = 1'b1;
                        ram_we                   = 1'b1;
                        ram_waddr                = free_idx;
                        ram_wdata.deadline       = arg_dl_reg;
                        ram_wdata.id             = idc_reg + 1'b1;
                        ram_wdata.tag            = tag_reg;
                        ram_wdata.cancelled      = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // One slot read per cycle; the selector sees it in the following cycle
                if (cnt_reg != CNT_W'(QUEUE_DEPTH))
                begin
                    ram_re    = 1'b1;
                    rvld_next = 1'b1;
                    ridx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                else if (!rvld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    tid_next  = '0;
                    ftag_next = '0;
                    hdl_next  = '0;
                    qe_next   = 1'b0;
                    fcnt_next = '0;
                    status_next = ST_OK;
                    last_next = 1'b1;
                    case (op_reg)
                        OP_CANCEL:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_CANCEL;
                            if (best.found)
                            begin
                                ram_we              = 1'b1;
                                ram_wdata.cancelled = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            state_next = S_IDLE;
                        end

                        OP_PROCESS:
                        begin
                            if (best.found &&
                                ($signed(best.entry.deadline) <= $signed(arg_dl_reg)) &&
                                (n_reg != FCNT_W'(MAX_FIRED)))
                            begin
                                // Pop the head, report it unless cancelled, scan again
                                valid_next[best.idx] = 1'b0;
                                if (!best.entry.cancelled)
                                begin
                                    out_valid_next = 1'b1;
                                    kind_next      = KIND_FIRED;
                                    tid_next       = best.entry.id;
                                    ftag_next      = best.entry.tag;
                                    hdl_next       = best.entry.deadline;
                                    last_next      = 1'b0;
                                    n_next         = n_reg + 1'b1;
                                end
                                cnt_next   = '0;
                                scan_clear = 1'b1;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_DONE;
                                fcnt_next      = n_reg;
                                state_next     = S_IDLE;
                            end
                        end

                        default:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_NEXT;
                            if (best.found)
                            begin
                                hdl_next = best.entry.deadline;
                            end
                            else
                            begin
                                qe_next = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            idc_reg       <= '0;
            cnt_reg       <= '0;
            rvld_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            idc_reg       <= idc_next;
            cnt_reg       <= cnt_next;
            rvld_reg      <= rvld_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        arg_dl_reg <= arg_dl_next;
        cb_reg     <= cb_next;
        tag_reg    <= tag_next;
        tgt_reg    <= tgt_next;
        ridx_reg   <= ridx_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        tid_reg    <= tid_next;
        ftag_reg   <= ftag_next;
        hdl_reg    <= hdl_next;
        qe_reg     <= qe_next;
        fcnt_reg   <= fcnt_next;
        last_reg   <= last_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign status        = status_reg;
    assign result_id     = tid_reg;
    assign fired_tag     = ftag_reg;
    assign head_deadline = hdl_reg;
    assign queue_empty   = qe_reg;
    assign fired_count   = fcnt_reg;
    assign last          = last_reg;

endmodule

// ----- hw/rtl/dtq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/dtq_scan.sv -----
// ----------------------------------------------------------------------------
// Deadline timer queue: ordering selector
// Keeps the earliest entry (deadline, then id) of a stream of RAM reads.
// ----------------------------------------------------------------------------
module dtq_scan
    import dtq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    clear,
    input  sample_t sample,
    output best_t   best
);

    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           entry_reg;
    best_t            best_next;
    logic             earlier;

    assign best = {found_reg, idx_reg, entry_reg};

    // Strict ordering; a full tie keeps the lower slot seen first
    always_comb
    begin
        if (sample.entry.deadline != best.entry.deadline)
        begin
            earlier = ($signed(sample.entry.deadline) < $signed(best.entry.deadline));
        end
        else
        begin
            earlier = (sample.entry.id < best.entry.id);
        end
    end

    always_comb
    begin
        best_next = best;
        if (clear)
        begin
            best_next.found = 1'b0;
        end
        else if (sample.vld && sample.hit && (!best.found || earlier))
        begin
            best_next.found = 1'b1;
            best_next.idx   = sample.idx;
            best_next.entry = sample.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= best_next.found;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= best_next.idx;
        entry_reg <= best_next.entry;
    end

endmodule

// ----- hw/rtl/dtq_checker.sv -----
// ----------------------------------------------------------------------------
// Deadline timer queue: port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_defines.svh"

module dtq_checker
    import dtq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [2:0]             kind,
    input logic [FCNT_W-1:0]      fired_count,
    input logic                   last
);

    // A held result stays offered
    `DTQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // Only one item in work: a transfer in closes the input side
    `DTQ_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input open after transfer")

    // Fired results are never final; every other kind is
    `DTQ_ASSERT_NOW(a_last_kind, out_valid, last != (kind == KIND_FIRED), "last flag wrong for kind")

    // Count stays within the fire limit
    `DTQ_ASSERT_NOW(a_count_range, out_valid && (kind == KIND_DONE),
                    fired_count <= FCNT_W'(MAX_FIRED), "fired count out of range")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

// ----- tb/sv/deadline_timer_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Watches both channels. Each input transfer is run through a local timer
// queue model, and the results it gives are queued. Each output transfer is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module deadline_timer_queue_checker
    import dtq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             operation,
    input  logic signed [DL_W-1:0] due_ms,
    input  logic                   has_callback,
    input  logic [TAG_W-1:0]       callback_tag,
    input  logic [ID_W-1:0]        target_id,
    input  logic signed [DL_W-1:0] now_ms,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [2:0]             kind,
    input  logic [1:0]             status,
    input  logic [ID_W-1:0]        result_id,
    input  logic [TAG_W-1:0]       fired_tag,
    input  logic signed [DL_W-1:0] head_deadline,
    input  logic                   queue_empty,
    input  logic [FCNT_W-1:0]      fired_count,
    input  logic                   last,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic [2:0]             kind;
        logic [1:0]             status;
        logic [ID_W-1:0]        id;
        logic [TAG_W-1:0]       tag;
        logic signed [DL_W-1:0] dl;
        logic                   empty;
        logic [FCNT_W-1:0]      cnt;
        logic                   last;
    } result_t;

    // Model of the queue contents
    logic                   q_used [QUEUE_DEPTH];
    logic signed [DL_W-1:0] q_dl   [QUEUE_DEPTH];
    logic [ID_W-1:0]        q_id   [QUEUE_DEPTH];
    logic [TAG_W-1:0]       q_tag  [QUEUE_DEPTH];
    logic                   q_dead [QUEUE_DEPTH];
    logic [ID_W-1:0]        next_id;

    result_t awaited [$];
    int      result_no;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h", result_no, what, got, want);
        errors++;
    endtask

    // Slot a orders strictly ahead of slot b
    function automatic bit ahead(input int a, input int b);
        if (q_dl[a] != q_dl[b])
            return q_dl[a] < q_dl[b];
        return q_id[a] < q_id[b];
    endfunction

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (q_used[i] && (best < 0 || ahead(i, best)))
                best = i;
        return best;
    endfunction

    function automatic result_t blank(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    // Work out the results of one input transfer
    task automatic predict();
        result_t r;
        int      slot;
        int      n;
        case (op_t'(operation))
            OP_ADD:
            begin
                r = blank(KIND_ADD);
                slot = -1;
                for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                    if (!q_used[i])
                        slot = i;
                if (!has_callback)
                    r.status = ST_NO_CB;
                else if (slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    next_id      = next_id + 1;
                    q_used[slot] = 1'b1;
                    q_dl[slot]   = due_ms;
                    q_id[slot]   = next_id;
                    q_tag[slot]  = callback_tag;
                    q_dead[slot] = 1'b0;
                    r.id         = next_id;
                end
                awaited.push_back(r);
            end
            OP_CANCEL:
            begin
                r = blank(KIND_CANCEL);
                slot = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (q_used[i] && q_id[i] == target_id && (slot < 0 || ahead(i, slot)))
                        slot = i;
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                    q_dead[slot] = 1'b1;
                awaited.push_back(r);
            end
            OP_PROCESS:
            begin
                n = 0;
                while (n < MAX_FIRED)
                begin
                    slot = earliest_slot();
                    if (slot < 0 || q_dl[slot] > now_ms)
                        break;
                    q_used[slot] = 1'b0;
                    if (!q_dead[slot])
                    begin
                        r      = blank(KIND_FIRED);
                        r.last = 1'b0;
                        r.id   = q_id[slot];
                        r.tag  = q_tag[slot];
                        r.dl   = q_dl[slot];
                        awaited.push_back(r);
                        n++;
                    end
                end
                r = blank(KIND_DONE);
                r.cnt = n[FCNT_W-1:0];
                awaited.push_back(r);
            end
            default:
            begin
                r = blank(KIND_NEXT);
                slot = earliest_slot();
                if (slot < 0)
                    r.empty = 1'b1;
                else
                    r.dl = q_dl[slot];
                awaited.push_back(r);
            end
        endcase
    endtask

    task automatic compare();
        result_t w;
        if (awaited.size() == 0)
        begin
            report("unexpected transfer, kind", 64'(kind), '0);
            return;
        end
        w = awaited.pop_front();
        if (kind !== w.kind)           report("kind", kind, w.kind);
        if (status !== w.status)       report("status", status, w.status);
        if (result_id !== w.id)        report("result_id", result_id, w.id);
        if (fired_tag !== w.tag)       report("fired_tag", fired_tag, w.tag);
        if (head_deadline !== w.dl)    report("head_deadline", head_deadline, w.dl);
        if (queue_empty !== w.empty)   report("queue_empty", queue_empty, w.empty);
        if (fired_count !== w.cnt)     report("fired_count", fired_count, w.cnt);
        if (last !== w.last)           report("last", last, w.last);
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                q_used[i] = 1'b0;
            next_id   = '0;
            result_no = 0;
            awaited.delete();
            pending   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                compare();
                result_no++;
            end
            if (in_valid && !in_stall)
                predict();
            pending = awaited.size();
        end
    end

endmodule

// ----- tb/sv/deadline_timer_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Directed items for the corner cases, then random traffic that fills and
// drains the queue, with bursty input and patterned output back-pressure.
// ----------------------------------------------------------------------------
module deadline_timer_queue_test
    import dtq_pkg::*;
;

    localparam int  RANDOM_ITEMS = 400;
    localparam int  CYCLE_LIMIT  = 5000000;
    localparam int  DRAIN_CYCLES = 2 * (QUEUE_DEPTH + 3);
    localparam logic signed [DL_W-1:0] DL_MIN = {1'b1, {(DL_W-1){1'b0}}};
    localparam logic signed [DL_W-1:0] DL_MAX = {1'b0, {(DL_W-1){1'b1}}};

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             operation;
    logic signed [DL_W-1:0] due_ms;
    logic                   has_callback;
    logic [TAG_W-1:0]       callback_tag;
    logic [ID_W-1:0]        target_id;
    logic signed [DL_W-1:0] now_ms;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             kind;
    logic [1:0]             status;
    logic [ID_W-1:0]        result_id;
    logic [TAG_W-1:0]       fired_tag;
    logic signed [DL_W-1:0] head_deadline;
    logic                   queue_empty;
    logic [FCNT_W-1:0]      fired_count;
    logic                   last;
    int                     errors;
    int                     pending;
    int                     cycles;
    int                     adds_sent;

    deadline_timer_queue dut (.*);
    deadline_timer_queue_checker checker_i (.*);

    // Clock and cycle limit
    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("deadline_timer_queue verification failed");
            $finish;
        end
    end

    // Output back-pressure: modes of none, light random and long holds
    int stall_mode;
    int stall_hold;
    initial
    begin
        out_stall  = 1'b0;
        stall_mode = 0;
        stall_hold = 0;
    end
    always @(negedge clk)
    begin
        if (cycles % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_hold > 0)
            stall_hold--;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 9) < 3);
        else if (stall_mode == 2)
        begin
            out_stall  <= ~out_stall;
            stall_hold = $urandom_range(0, 15);
        end
        else
            out_stall <= 1'b0;
    end

    // One input transfer; fields change at the falling edge
    task automatic send(input op_t op, input logic signed [DL_W-1:0] dl, input logic cb,
                        input logic [TAG_W-1:0] tag, input logic [ID_W-1:0] tid,
                        input logic signed [DL_W-1:0] now);
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        due_ms       <= dl;
        has_callback <= cb;
        callback_tag <= tag;
        target_id    <= tid;
        now_ms       <= now;
        if (op == OP_ADD && cb)
            adds_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [DL_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return DL_MIN;
            1:       return DL_MAX;
            2, 3:    return DL_W'({$urandom, $urandom});
            default: return $signed(48'($urandom_range(0, 40))) - 48'sd20;
        endcase
    endfunction

    int burst_left;
    int fill_mode;
    int pick;
    op_t op;

    // Stimulus
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_QUERY;
        due_ms       = '0;
        has_callback = 1'b0;
        callback_tag = '0;
        target_id    = '0;
        now_ms       = '0;
        adds_sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners
        send(OP_QUERY,   '0, 1'b0, '0, '0, '0);          // empty head
        send(OP_PROCESS, '0, 1'b0, '0, '0, DL_MAX);      // nothing to fire
        send(OP_ADD, DL_MAX, 1'b0, '1, '0, '0);          // no callback
        send(OP_ADD, DL_MIN, 1'b1, '0, '0, '0);          // id 1
        send(OP_ADD, DL_MAX, 1'b1, '1, '1, '1);          // id 2
        send(OP_ADD, '0,     1'b1, 32'hA5A5_5A5A, '0, '0); // id 3
        send(OP_ADD, '0,     1'b1, 32'h5A5A_A5A5, '0, '0); // id 4, tie on deadline
        send(OP_QUERY,  '0, 1'b0, '0, '0, '0);
        send(OP_CANCEL, '0, 1'b0, '0, 32'd1, '0);
        send(OP_CANCEL, '0, 1'b0, '0, 32'd1, '0);        // already cancelled
        send(OP_CANCEL, '0, 1'b0, '0, 32'd0, '0);        // not found
        send(OP_CANCEL, '1, 1'b1, '1, '1, '0);           // not found
        send(OP_QUERY,  '0, 1'b0, '0, '0, '0);           // cancelled head still reported
        send(OP_PROCESS, '0, 1'b0, '0, '0, DL_MIN);      // pops cancelled head only
        send(OP_CANCEL, '0, 1'b0, '0, 32'd4, '0);
        send(OP_PROCESS, '0, 1'b0, '0, '0, 48'sd0);      // ties at now
        send(OP_PROCESS, '0, 1'b0, '0, '0, DL_MAX);      // drains the rest
        send(OP_QUERY,   '0, 1'b0, '0, '0, '0);

        // Random traffic: fill phases push the queue to full, drain phases empty it
        burst_left = 0;
        fill_mode  = 1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                fill_mode = $urandom_range(0, 1);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0)
                    idle($urandom_range(1, 8));
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (fill_mode)
                op = pick < 75 ? OP_ADD : pick < 85 ? OP_CANCEL : pick < 92 ? OP_QUERY
                                                                             : OP_PROCESS;
            else
                op = pick < 25 ? OP_ADD : pick < 45 ? OP_CANCEL : pick < 60 ? OP_QUERY
                                                                             : OP_PROCESS;
            send(op, pick_time(), ($urandom_range(0, 9) != 0), $urandom,
                 ($urandom_range(0, 4) != 0) ? 32'($urandom_range(0, adds_sent + 1))
                                             : 32'($urandom),
                 ($urandom_range(0, 3) == 0) ? DL_MAX : pick_time());
        end
        idle(0);

        // Wait for the last results, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("deadline_timer_queue verification clean");
        else
            $display("deadline_timer_queue verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_scan.sv
hw/rtl/deadline_timer_queue.sv
hw/rtl/dtq_checker.sv
tb/sv/deadline_timer_queue_checker.sv
tb/sv/deadline_timer_queue_test.sv
